>>> src/dcps_pkg.sv
`default_nettype none
package dcps_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int IDX_W = $clog2(MAX_PARTICLES);
    // position x, position y, motion x, motion y, accel x, accel y, inverse mass
    localparam int ENTRY_W = 32 * 6 + 24;

    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_LINK      = 2'd1,
        CMD_INTEGRATE = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    localparam logic [0:0] REG_TIME_STEP   = 1'b0;
    localparam logic [0:0] REG_VERLET_MODE = 1'b1;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [23:0]        im;
    } entry_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic clips(input logic signed [65:0] v);
        return (v > 66'sd2147483647) || (v < -66'sd2147483648);
    endfunction

endpackage
`default_nettype wire

>>> src/dcps_ram.sv
`default_nettype none
module dcps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> src/distance_constraint_particle_solver.sv
`default_nettype none
//  channel   ports                                          direction
//  command   start/busy, command, index_a/b, load_*, accel_*, inv_mass, rest_length   in
//  result    done, out_index, out_x, out_y, saturated       out
//  config    cfg_we, cfg_index, cfg_data                    in
//
//  one request at a time; busy is high from acceptance until the result strobe
//  a link runs the 34-step square root, then, unless degenerate, four restoring
//  divides in one shared divider and four products
//  state sits in one 1024 x 216 particle ram with a registered read
//  rst_n resets control and config only; the ram is never cleared
//  the receiver cannot stall: done pulses for one cycle
module distance_constraint_particle_solver (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   command,
    input  wire logic [9:0]                   index_a,
    input  wire logic [9:0]                   index_b,
    input  wire logic signed [31:0]           load_x,
    input  wire logic signed [31:0]           load_y,
    input  wire logic signed [31:0]           accel_x,
    input  wire logic signed [31:0]           accel_y,
    input  wire logic [23:0]                  inv_mass,
    input  wire logic [31:0]                  rest_length,
    output logic                              done,
    output logic [9:0]                        out_index,
    output logic signed [31:0]                out_x,
    output logic signed [31:0]                out_y,
    output logic                              saturated,
    input  wire logic                         cfg_we,
    input  wire logic [0:0]                   cfg_index,
    input  wire logic [15:0]                  cfg_data
);
    import dcps_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000000000000001,
        S_RDA    = 16'b0000000000000010,
        S_WAITA  = 16'b0000000000000100,
        S_RDB    = 16'b0000000000001000,
        S_SQSUM  = 16'b0000000000010000,
        S_SQRT   = 16'b0000000000100000,
        S_SQMUL  = 16'b0000000001000000,
        S_DIVSET = 16'b0000000010000000,
        S_DIV    = 16'b0000000100000000,
        S_MULF   = 16'b0000001000000000,
        S_WRA    = 16'b0000010000000000,
        S_WRB    = 16'b0000100000000000,
        S_INT1   = 16'b0001000000000000,
        S_INT2   = 16'b0010000000000000,
        S_INT3   = 16'b0100000000000000,
        S_OUT    = 16'b1000000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] dt_reg;
    logic        verlet_reg;

    // request latch
    cmd_t              cmd_reg;
    logic [IDX_W-1:0]  ia_reg, ib_reg;
    logic [31:0]       rest_reg;

    // ram
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;

    dcps_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PARTICLES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    entry_t ea_reg, eb_reg;
    logic   clip_reg;

    // link datapath
    logic signed [32:0] dx_reg, dy_reg;
    logic [63:0]        sqsum_hi_reg, sqsum_lo_reg;  // dx and dy squared, summed later into the 66-bit sq_reg
    logic [65:0]        sq_reg;
    logic [33:0]        root_reg;
    logic [5:0]         bit_reg;
    logic [67:0]        tsq_reg;
    logic [33:0]        len_reg;
    logic signed [34:0] e_reg;
    // divide job: 0 fa, 1 fb, 2 ux, 3 uy
    logic [1:0]         job_reg;
    logic [64:0]        num_reg;
    logic [34:0]        den_reg;
    logic [35:0]        rem_reg;
    logic [6:0]         dcnt_reg;
    logic [34:0]        fa_reg, fb_reg;
    logic [32:0]        ux_reg, uy_reg;
    logic [1:0]         mjob_reg;
    logic signed [35:0] sax_reg, say_reg, sbx_reg, sby_reg;

    // integrate products
    logic [31:0]        dt2_reg;
    logic signed [65:0] tx_reg, ty_reg;

    logic [IDX_W-1:0]   out_idx_reg;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg     <= 16'd1092;
            verlet_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIME_STEP:   dt_reg     <= cfg_data;
                REG_VERLET_MODE: verlet_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);

    function automatic logic [63:0] umag(input logic signed [35:0] v);
        return v[35] ? 64'(-v) : 64'(v);
    endfunction

    // trunc(a*b >> sh) toward zero, signed a, unsigned b
    function automatic logic signed [65:0] mulsh(input logic signed [32:0] a,
                                                 input logic [31:0] b,
                                                 input int sh);
        logic [64:0] m;
        logic [64:0] r;
        m = (a[32] ? 65'(-a) : 65'(a)) * 65'(b);
        r = m >> sh;
        return a[32] ? -66'(r) : 66'(r);
    endfunction

    // ram port control
    always_comb
    begin
        ram_raddr = ia_reg;
        if (state_reg == S_IDLE)
        begin
            ram_raddr = index_a[IDX_W-1:0];
        end
        else if (state_reg == S_RDA && cmd_reg == CMD_LINK)
        begin
            ram_raddr = ib_reg;
        end
        else if (state_reg == S_OUT || state_reg == S_WRB || state_reg == S_WRA)
        begin
            ram_raddr = ia_reg;
        end
    end

    // write path
    logic signed [65:0] wa_x, wa_y, wb_x, wb_y;
    logic signed [65:0] vx, vy, nx, ny;
    logic signed [31:0] vxs, vys;
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ia_reg;
        ram_wdata = ea_reg;
        wa_x = 66'(ea_reg.px) - 66'(sax_reg);
        wa_y = 66'(ea_reg.py) - 66'(say_reg);
        wb_x = 66'(eb_reg.px) + 66'(sbx_reg);
        wb_y = 66'(eb_reg.py) + 66'(sby_reg);
        vx = 66'(ea_reg.mx) + tx_reg;
        vy = 66'(ea_reg.my) + ty_reg;
        vxs = sat32(vx);
        vys = sat32(vy);
        nx = 66'(ea_reg.px) + 66'(ea_reg.px) - 66'(ea_reg.mx) + tx_reg;
        ny = 66'(ea_reg.py) + 66'(ea_reg.py) - 66'(ea_reg.my) + ty_reg;
        case (state_reg)
            S_RDA:
            begin
                if (cmd_reg == CMD_LOAD)
                begin
                    ram_we = 1'b1;
                    ram_wdata = ea_reg;
                end
            end
            S_WRA:
            begin
                ram_we = 1'b1;
                ram_wdata = ea_reg;
                ram_wdata.px = sat32(wa_x);
                ram_wdata.py = sat32(wa_y);
            end
            S_WRB:
            begin
                ram_we = 1'b1;
                ram_waddr = ib_reg;
                ram_wdata = eb_reg;
                ram_wdata.px = sat32(wb_x);
                ram_wdata.py = sat32(wb_y);
            end
            S_INT3:
            begin
                ram_we = 1'b1;
                ram_wdata = ea_reg;
                if (verlet_reg)
                begin
                    ram_wdata.mx = ea_reg.px;
                    ram_wdata.my = ea_reg.py;
                    ram_wdata.px = sat32(nx);
                    ram_wdata.py = sat32(ny);
                end
                else
                begin
                    ram_wdata.mx = vxs;
                    ram_wdata.my = vys;
                    ram_wdata.px = sat32(66'(ea_reg.px) + mulsh(33'(vxs), 32'(dt_reg), 16));
                    ram_wdata.py = sat32(66'(ea_reg.py) + mulsh(33'(vys), 32'(dt_reg), 16));
                end
            end
            default: ;
        endcase
    end

    logic [67:0] cand_sq;
    logic [33:0] cand;
    always_comb
    begin
        cand = root_reg | (34'd1 << bit_reg);
        cand_sq = tsq_reg;
    end

    // divider step, 64-bit dividend in num_reg[63:0]
    logic [35:0] rem_sh;
    logic [35:0] rem_sub;
    always_comb
    begin
        rem_sh  = {rem_reg[34:0], num_reg[63]};
        rem_sub = rem_sh - 36'(den_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= (state_next == S_IDLE) && (state_reg == S_OUT);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (start) state_next = S_RDA;
            S_RDA:
            begin
                case (cmd_reg)
                    CMD_LOAD:      state_next = S_WAITA;
                    CMD_LINK:      state_next = S_RDB;
                    CMD_INTEGRATE: state_next = S_INT1;
                    default:       state_next = S_OUT;
                endcase
            end
            S_WAITA:  state_next = S_OUT;
            S_RDB:    state_next = S_SQSUM;
            S_SQSUM:  state_next = S_SQMUL;
            S_SQMUL:  state_next = S_SQRT;
            S_SQRT:
            begin
                if (bit_reg == 6'd0)
                begin
                    state_next = S_DIVSET;
                end
                else
                begin
                    state_next = S_SQMUL;
                end
            end
            S_DIVSET:
            begin
                if (len_reg == '0 || (ea_reg.im == '0 && eb_reg.im == '0))
                    state_next = S_OUT;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (dcnt_reg == '0)
                    state_next = (job_reg == 2'd3) ? S_MULF : S_DIV;
            end
            S_MULF:   if (mjob_reg == 2'd3) state_next = S_WRA;
            S_WRA:    state_next = S_WRB;
            S_WRB:    state_next = S_OUT;
            S_INT1:   state_next = S_INT2;
            S_INT2:   state_next = S_INT3;
            // a spare state, S_WAITA, so the read of entry a sees the write
            S_INT3:   state_next = S_WAITA;
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath
    logic [64:0] wsum;
    assign wsum = 65'(ea_reg.im) + 65'(eb_reg.im);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_reg   <= cmd_t'(command);
                    ia_reg    <= index_a[IDX_W-1:0];
                    ib_reg    <= index_b[IDX_W-1:0];
                    rest_reg  <= rest_length;
                    clip_reg  <= 1'b0;
                    ea_reg.px <= load_x;
                    ea_reg.py <= load_y;
                    ea_reg.mx <= verlet_reg ? load_x : 32'sd0;
                    ea_reg.my <= verlet_reg ? load_y : 32'sd0;
                    ea_reg.ax <= accel_x;
                    ea_reg.ay <= accel_y;
                    ea_reg.im <= inv_mass;
                end
            end
            S_RDA:
            begin
                if (cmd_reg != CMD_LOAD)
                begin
                    ea_reg <= ram_rdata;
                end
            end
            S_RDB:
            begin
                eb_reg <= ram_rdata;
                dx_reg <= 33'(ea_reg.px) - 33'(ram_rdata.px);
                dy_reg <= 33'(ea_reg.py) - 33'(ram_rdata.py);
            end
            S_SQSUM:
            begin
                sqsum_hi_reg <= 64'(dx_reg * dx_reg);
                sqsum_lo_reg <= 64'(dy_reg * dy_reg);
                root_reg     <= '0;
                bit_reg      <= 6'd33;
            end
            S_SQMUL:
            begin
                sq_reg  <= 66'(sqsum_hi_reg) + 66'(sqsum_lo_reg);
                tsq_reg <= 68'(cand) * 68'(cand);
            end
            S_SQRT:
            begin
                if (cand_sq <= 68'(sq_reg))
                begin
                    root_reg <= cand;
                end
                if (bit_reg != 6'd0)
                begin
                    bit_reg <= bit_reg - 6'd1;
                end
                else
                begin
                    len_reg <= (cand_sq <= 68'(sq_reg)) ? cand : root_reg;
                end
            end
            S_DIVSET:
            begin
                e_reg   <= 35'(len_reg) - 35'(rest_reg);
                job_reg <= 2'd0;
                num_reg <= 65'(umag(36'(35'(len_reg) - 35'(rest_reg)))) * 65'(ea_reg.im);
                den_reg <= 35'(wsum);
                rem_reg <= '0;
                dcnt_reg <= 7'd64;
            end
            S_DIV:
            begin
                if (dcnt_reg != '0)
                begin
                    if (!rem_sub[35])
                    begin
                        rem_reg <= rem_sub;
                        num_reg <= {num_reg[63:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        num_reg <= {num_reg[63:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 7'd1;
                end
                else
                begin
                    rem_reg  <= '0;
                    dcnt_reg <= 7'd64;
                    job_reg  <= job_reg + 2'd1;
                    mjob_reg <= 2'd0;
                    case (job_reg)
                        2'd0:
                        begin
                            fa_reg  <= num_reg[34:0];
                            num_reg <= 65'(umag(36'(e_reg))) * 65'(eb_reg.im);
                        end
                        2'd1:
                        begin
                            fb_reg  <= num_reg[34:0];
                            num_reg <= 65'(umag(36'(dx_reg))) << 31;
                            den_reg <= 35'(len_reg);
                        end
                        2'd2:
                        begin
                            ux_reg  <= num_reg[32:0];
                            num_reg <= 65'(umag(36'(dy_reg))) << 31;
                        end
                        default: uy_reg <= num_reg[32:0];
                    endcase
                end
            end
            S_MULF:
            begin
                mjob_reg <= mjob_reg + 2'd1;
                case (mjob_reg)
                    2'd0: sax_reg <= (e_reg[34] ^ dx_reg[32])
                        ? -36'((68'(fa_reg) * 68'(ux_reg)) >> 31)
                        :  36'((68'(fa_reg) * 68'(ux_reg)) >> 31);
                    2'd1: say_reg <= (e_reg[34] ^ dy_reg[32])
                        ? -36'((68'(fa_reg) * 68'(uy_reg)) >> 31)
                        :  36'((68'(fa_reg) * 68'(uy_reg)) >> 31);
                    2'd2: sbx_reg <= (e_reg[34] ^ dx_reg[32])
                        ? -36'((68'(fb_reg) * 68'(ux_reg)) >> 31)
                        :  36'((68'(fb_reg) * 68'(ux_reg)) >> 31);
                    default: sby_reg <= (e_reg[34] ^ dy_reg[32])
                        ? -36'((68'(fb_reg) * 68'(uy_reg)) >> 31)
                        :  36'((68'(fb_reg) * 68'(uy_reg)) >> 31);
                endcase
            end
            S_WRA:
            begin
                clip_reg <= clips(wa_x) | clips(wa_y);
            end
            S_WRB:
            begin
                clip_reg <= clip_reg | clips(wb_x) | clips(wb_y);
            end
            S_INT1:
            begin
                dt2_reg <= 32'(dt_reg) * 32'(dt_reg);
            end
            S_INT2:
            begin
                if (verlet_reg)
                begin
                    tx_reg <= mulsh(33'(ea_reg.ax), dt2_reg, 32);
                    ty_reg <= mulsh(33'(ea_reg.ay), dt2_reg, 32);
                end
                else
                begin
                    tx_reg <= mulsh(33'(ea_reg.ax), 32'(dt_reg), 16);
                    ty_reg <= mulsh(33'(ea_reg.ay), 32'(dt_reg), 16);
                end
            end
            S_INT3:
            begin
                if (verlet_reg)
                    clip_reg <= clips(nx) | clips(ny);
                else
                    clip_reg <= clips(vx) | clips(vy)
                        | clips(66'(ea_reg.px) + mulsh(33'(vxs), 32'(dt_reg), 16))
                        | clips(66'(ea_reg.py) + mulsh(33'(vys), 32'(dt_reg), 16));
            end
            default: ;
        endcase
    end

    // result: ram read of entry a issued in S_OUT's predecessor lands now
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT)
        begin
            out_idx_reg <= ia_reg;
            out_x       <= ram_rdata.px;
            out_y       <= ram_rdata.py;
            saturated   <= clip_reg;
        end
    end

    assign out_index = 10'(out_idx_reg);
endmodule
`default_nettype wire

>>> dv/tb_distance_constraint_particle_solver.sv
module tb_distance_constraint_particle_solver;
    import dcps_pkg::*;

    // one command as the driver holds it
    typedef struct {
        cmd_t               command;
        logic [9:0]         index_a;
        logic [9:0]         index_b;
        logic signed [31:0] load_x;
        logic signed [31:0] load_y;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic [23:0]        inv_mass;
        logic [31:0]        rest_length;
    } request_t;

    // one particle report as the block returns it
    typedef struct {
        logic [9:0]         index;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sat;
    } report_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               done;
    logic [9:0]         out_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               saturated;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [15:0]        cfg_data;
    request_t           cur;

    distance_constraint_particle_solver u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (cur.command),
        .index_a     (cur.index_a),
        .index_b     (cur.index_b),
        .load_x      (cur.load_x),
        .load_y      (cur.load_y),
        .accel_x     (cur.accel_x),
        .accel_y     (cur.accel_y),
        .inv_mass    (cur.inv_mass),
        .rest_length (cur.rest_length),
        .done        (done),
        .out_index   (out_index),
        .out_x       (out_x),
        .out_y       (out_y),
        .saturated   (saturated),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock, period 2
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // particle memory as the testbench sees it
    int          pos_x [MAX_PARTICLES];
    int          pos_y [MAX_PARTICLES];
    int          mot_x [MAX_PARTICLES];
    int          mot_y [MAX_PARTICLES];
    int          acc_x [MAX_PARTICLES];
    int          acc_y [MAX_PARTICLES];
    logic [23:0] imass [MAX_PARTICLES];
    logic [15:0] step_dt;
    logic        verlet_on;

    request_t pending_q[$];     // requests not yet driven
    report_t  report_q[$];      // predicted reports, oldest first
    int       errors;
    int       served;           // requests accepted so far
    bit       taken;            // request accepted at the last rising edge
    bit       hold_requests;

    // indexes loaded so far, tracked at queueing time
    bit       loaded [MAX_PARTICLES];
    int       loaded_list[$];

    // ---------------------------------------------------------------
    // fixed point helpers for the prediction
    // ---------------------------------------------------------------
    function automatic longint unsigned magn(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic int clip32(input longint v, inout bit clip);
        if (v > 64'sd2147483647)
        begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    // a * b / 2^sh, rounded toward zero
    function automatic longint scale_trunc(input longint a, input longint unsigned b,
                                           input int sh);
        longint unsigned r;
        r = (magn(a) * b) >> sh;
        return a < 0 ? -longint'(r) : longint'(r);
    endfunction

    // floor(sqrt(ax^2 + ay^2)), bit by bit
    function automatic longint unsigned link_length(input longint unsigned ax,
                                                    input longint unsigned ay);
        logic [127:0] sq;
        logic [127:0] tt;
        logic [63:0]  r;
        logic [63:0]  t;
        sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        r  = '0;
        for (int b = 33; b >= 0; b--)
        begin
            t  = r | (64'd1 << b);
            tt = 128'(t) * 128'(t);
            if (tt <= sq)
                r = t;
        end
        return r;
    endfunction

    // correction of one end along one axis; products wrap at 64 bits
    function automatic longint axis_shift(input longint err, input longint unsigned w,
                                          input longint unsigned wsum, input longint d,
                                          input longint unsigned len);
        longint unsigned f;
        longint unsigned u;
        longint unsigned s;
        f = (magn(err) * w) / wsum;
        u = (magn(d) << 31) / len;
        s = (f * u) >> 31;
        return ((err < 0) != (d < 0)) ? -longint'(s) : longint'(s);
    endfunction

    // apply one request to the particle memory, return the expected report
    function automatic report_t solve_request(input request_t rq);
        report_t         rp;
        bit              clip;
        int              a;
        int              b;
        longint          dx;
        longint          dy;
        longint          err;
        longint          px;
        longint          py;
        longint          xb;
        longint          yb;
        longint          sax;
        longint          say;
        longint          sbx;
        longint          sby;
        longint unsigned len;
        longint unsigned wa;
        longint unsigned wb;
        longint unsigned dt;
        clip = 1'b0;
        a    = rq.index_a % MAX_PARTICLES;
        b    = rq.index_b % MAX_PARTICLES;
        dt   = step_dt;
        case (rq.command)
            CMD_LOAD:
            begin
                pos_x[a] = rq.load_x;
                pos_y[a] = rq.load_y;
                acc_x[a] = rq.accel_x;
                acc_y[a] = rq.accel_y;
                imass[a] = rq.inv_mass;
                mot_x[a] = verlet_on ? rq.load_x : 0;
                mot_y[a] = verlet_on ? rq.load_y : 0;
            end
            CMD_LINK:
            begin
                dx  = longint'(pos_x[a]) - longint'(pos_x[b]);
                dy  = longint'(pos_y[a]) - longint'(pos_y[b]);
                len = link_length(magn(dx), magn(dy));
                wa  = imass[a];
                wb  = imass[b];
                // degenerate link: zero length or both ends fixed
                if (len != 0 && (wa + wb) != 0)
                begin
                    err = longint'(len) - longint'(rq.rest_length);
                    sax = axis_shift(err, wa, wa + wb, dx, len);
                    say = axis_shift(err, wa, wa + wb, dy, len);
                    sbx = axis_shift(err, wb, wa + wb, dx, len);
                    sby = axis_shift(err, wb, wa + wb, dy, len);
                    xb  = pos_x[b];
                    yb  = pos_y[b];
                    pos_x[a] = clip32(longint'(pos_x[a]) - sax, clip);
                    pos_y[a] = clip32(longint'(pos_y[a]) - say, clip);
                    pos_x[b] = clip32(xb + sbx, clip);
                    pos_y[b] = clip32(yb + sby, clip);
                end
            end
            CMD_INTEGRATE:
            begin
                if (verlet_on)
                begin
                    px = pos_x[a];
                    py = pos_y[a];
                    pos_x[a] = clip32(px + (px - mot_x[a])
                                      + scale_trunc(acc_x[a], dt * dt, 32), clip);
                    pos_y[a] = clip32(py + (py - mot_y[a])
                                      + scale_trunc(acc_y[a], dt * dt, 32), clip);
                    mot_x[a] = int'(px);
                    mot_y[a] = int'(py);
                end
                else
                begin
                    mot_x[a] = clip32(longint'(mot_x[a]) + scale_trunc(acc_x[a], dt, 16), clip);
                    mot_y[a] = clip32(longint'(mot_y[a]) + scale_trunc(acc_y[a], dt, 16), clip);
                    pos_x[a] = clip32(longint'(pos_x[a]) + scale_trunc(mot_x[a], dt, 16), clip);
                    pos_y[a] = clip32(longint'(pos_y[a]) + scale_trunc(mot_y[a], dt, 16), clip);
                end
            end
            default:
            begin
            end
        endcase
        rp.index = a[9:0];
        rp.x     = pos_x[a];
        rp.y     = pos_y[a];
        rp.sat   = clip;
        return rp;
    endfunction

    // ---------------------------------------------------------------
    // request building
    // ---------------------------------------------------------------
    function automatic request_t make_request(input cmd_t c, input logic [9:0] ia,
                                              input logic [9:0] ib, input logic [31:0] lx,
                                              input logic [31:0] ly, input logic [31:0] ax,
                                              input logic [31:0] ay, input logic [23:0] im,
                                              input logic [31:0] rest);
        request_t rq;
        rq.command     = c;
        rq.index_a     = ia;
        rq.index_b     = ib;
        rq.load_x      = lx;
        rq.load_y      = ly;
        rq.accel_x     = ax;
        rq.accel_y     = ay;
        rq.inv_mass    = im;
        rq.rest_length = rest;
        return rq;
    endfunction

    task automatic push_request(input request_t rq);
        if (rq.command == CMD_LOAD && !loaded[rq.index_a])
        begin
            loaded[rq.index_a] = 1'b1;
            loaded_list.push_back(rq.index_a);
        end
        pending_q.push_back(rq);
    endtask

    // positions mostly in a range where links and steps stay meaningful
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_accel();
        if ($urandom_range(0, 99) < 70)
            return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        return $urandom;
    endfunction

    task automatic queue_random(input int count);
        request_t    rq;
        int          pick;
        logic [9:0]  ia;
        logic [9:0]  ib;
        logic [23:0] im;
        logic [31:0] rest;
        cmd_t        c;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (loaded_list.size() < 2 || pick < 25)
                c = CMD_LOAD;
            else if (pick < 60)
                c = CMD_LINK;
            else if (pick < 85)
                c = CMD_INTEGRATE;
            else
                c = CMD_READ;
            // unused fields of other commands carry noise
            ib   = $urandom;
            rest = $urandom_range(0, 99) < 60 ? $urandom_range(0, 32'h0080_0000) : $urandom;
            pick = $urandom_range(0, 99);
            im   = pick < 15 ? 24'd0 : (pick < 30 ? 24'($urandom) : 24'($urandom_range(1, 1 << 17)));
            if (c == CMD_LOAD)
            begin
                // a small pool keeps links and integrates dense
                if ($urandom_range(0, 99) < 70)
                    ia = $urandom_range(0, 1) ? 10'($urandom_range(0, 15))
                                              : 10'($urandom_range(1008, 1023));
                else
                    ia = $urandom;
            end
            else
            begin
                ia = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                if (c == CMD_LINK)
                    ib = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            end
            rq = make_request(c, ia, ib, rand_coord(), rand_coord(), rand_accel(),
                              rand_accel(), im, rest);
            push_request(rq);
        end
    endtask

    task automatic queue_directed();
        // plain pair and a normal link
        push_request(make_request(CMD_LOAD, 10'd0, 10'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                                  24'h010000, 32'd0));
        push_request(make_request(CMD_LOAD, 10'd1023, 10'd0, 32'h0003_0000, 32'h0004_0000,
                                  32'd0, -32'sd642252, 24'h010000, 32'd0));
        push_request(make_request(CMD_LINK, 10'd0, 10'd1023, 32'd0, 32'd0, 32'd0, 32'd0,
                                  24'd0, 32'h0001_0000));
        // link of a particle with itself
        push_request(make_request(CMD_LINK, 10'd0, 10'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                                  24'd0, 32'd5));
        // two particles on the same spot: zero length
        push_request(make_request(CMD_LOAD, 10'd5, 10'd0, 32'd100, 32'd100, 32'd0, 32'd0,
                                  24'd1, 32'd0));
        push_request(make_request(CMD_LOAD, 10'd6, 10'd0, 32'd100, 32'd100, 32'd0, 32'd0,
                                  24'hffffff, 32'd0));
        push_request(make_request(CMD_LINK, 10'd5, 10'd6, 32'd0, 32'd0, 32'd0, 32'd0,
                                  24'd0, 32'd7));
        // both ends fixed
        push_request(make_request(CMD_LOAD, 10'd7, 10'd0, 32'h0010_0000, 32'd0, 32'd0, 32'd0,
                                  24'd0, 32'd0));
        push_request(make_request(CMD_LOAD, 10'd8, 10'd0, 32'd0, 32'h0010_0000, 32'd0, 32'd0,
                                  24'd0, 32'd0));
        push_request(make_request(CMD_LINK, 10'd7, 10'd8, 32'd0, 32'd0, 32'd0, 32'd0,
                                  24'd0, 32'd0));
        // extremes that saturate on integration
        push_request(make_request(CMD_LOAD, 10'd9, 10'h3ff, 32'h7fffffff, 32'h80000000,
                                  32'h7fffffff, 32'h80000000, 24'hffffff, 32'hffffffff));
        push_request(make_request(CMD_INTEGRATE, 10'd9, 10'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                                  24'd0, 32'd0));
        push_request(make_request(CMD_INTEGRATE, 10'd9, 10'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                                  24'd0, 32'd0));
        // opposite corners: longest link, rest zero then rest at its maximum
        push_request(make_request(CMD_LOAD, 10'd10, 10'd0, 32'h80000000, 32'h7fffffff,
                                  32'd0, 32'd0, 24'hffffff, 32'd0));
        push_request(make_request(CMD_LOAD, 10'd11, 10'd0, 32'h7fffffff, 32'h80000000,
                                  32'd0, 32'd0, 24'hffffff, 32'd0));
        push_request(make_request(CMD_LINK, 10'd10, 10'd11, 32'd0, 32'd0, 32'd0, 32'd0,
                                  24'd0, 32'd0));
        push_request(make_request(CMD_LINK, 10'd11, 10'd10, 32'd0, 32'd0, 32'd0, 32'd0,
                                  24'd0, 32'hffffffff));
        push_request(make_request(CMD_INTEGRATE, 10'd1023, 10'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                                  24'd0, 32'd0));
        push_request(make_request(CMD_READ, 10'd1023, 10'h3ff, 32'hffffffff, 32'hffffffff,
                                  32'hffffffff, 32'hffffffff, 24'hffffff, 32'hffffffff));
        push_request(make_request(CMD_READ, 10'd0, 10'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                                  24'd0, 32'd0));
    endtask

    // ---------------------------------------------------------------
    // configuration and phase control
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == REG_TIME_STEP)
            step_dt = val;
        else
            verlet_on = val[0];
    endtask

    // sender pauses until every predicted report has come back
    task automatic wait_drained();
        @(negedge clk);
        while (pending_q.size() != 0 || start || report_q.size() != 0 || busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h (request %0d)", what, got, want, served);
        errors++;
    endtask

    // ---------------------------------------------------------------
    // driver: new request at the falling edge once the last one is taken
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!start || taken))
        begin
            taken = 1'b0;
            // no idling in a stretch of the middle of the run
            if (pending_q.size() != 0 && !hold_requests
                && ((served >= 150 && served < 260) || $urandom_range(0, 99) >= 17))
            begin
                cur   <= pending_q.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // monitor: predict on acceptance, check each strobed report
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                report_q.push_back(solve_request(cur));
                taken = 1'b1;
                served++;
            end
            if (done)
            begin
                if (report_q.size() == 0)
                begin
                    $display("unexpected report for particle %0d", out_index);
                    errors++;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (out_index !== want.index)
                        report_mismatch("index", 32'(out_index), 32'(want.index));
                    if (out_x !== want.x)
                        report_mismatch("x", out_x, want.x);
                    if (out_y !== want.y)
                        report_mismatch("y", out_y, want.y);
                    if (saturated !== want.sat)
                        report_mismatch("saturated", 32'(saturated), 32'(want.sat));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // run sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_TIME_STEP;
        cfg_data      = '0;
        cur           = make_request(CMD_READ, '0, '0, '0, '0, '0, '0, '0, '0);
        step_dt       = 16'd1092;
        verlet_on     = 1'b1;
        errors        = 0;
        served        = 0;
        taken         = 1'b0;
        hold_requests = 1'b0;
        for (int i = 0; i < MAX_PARTICLES; i++)
            loaded[i] = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // reset settings first
        queue_directed();
        queue_random(55);
        wait_drained();

        // zero step, then Euler at the extremes, then random steps
        write_reg(REG_TIME_STEP, 16'd0);
        queue_random(60);
        wait_drained();
        write_reg(REG_TIME_STEP, 16'hffff);
        write_reg(REG_VERLET_MODE, 1'b0);
        queue_random(70);
        wait_drained();
        write_reg(REG_TIME_STEP, 16'd1);
        queue_random(60);
        wait_drained();
        write_reg(REG_TIME_STEP, 16'($urandom));
        queue_random(70);
        wait_drained();
        // back to Verlet, which stores the previous position as motion
        write_reg(REG_VERLET_MODE, 1'b1);
        write_reg(REG_TIME_STEP, 16'hffff);
        queue_random(60);
        wait_drained();
        write_reg(REG_TIME_STEP, 16'($urandom_range(256, 4096)));
        queue_random(55);
        wait_drained();
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("PASS distance_constraint_particle_solver");
        else
            $display("FAIL distance_constraint_particle_solver");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("FAIL distance_constraint_particle_solver");
        $finish;
    end

endmodule

>>> files.f
src/dcps_pkg.sv
src/dcps_ram.sv
src/distance_constraint_particle_solver.sv
dv/tb_distance_constraint_particle_solver.sv
